// File: design/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, ante, cons)
`endif
`endif

// File: design/aarm_pkg.sv
// Package with types, constants and the arctangent table of the rotation matrix block.
package aarm_pkg;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int FRAC_BITS_DEF     = 14;
  localparam int TABLE_LEN         = 24;
  localparam int WORK_BITS         = 30;
  localparam int XW                = 34;
  localparam int QUEUE_DEPTH       = 4;
  localparam int OUT_DEPTH         = 2;
  localparam logic signed [XW-1:0] GAIN_Q30 = 34'sd652032874;

  typedef struct packed {
    logic               flip;
    logic signed [31:0] z;
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
  } front_item_t;

  typedef struct packed {
    logic               flip;
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
  } pass_t;

  typedef struct packed {
    logic stall;
    logic busy;
  } back_st_t;

  function automatic logic [31:0] atan_turn(input int idx);
    logic [31:0] v;
    case (idx)
      0:  v = 32'h20000000;
      1:  v = 32'h12E4051E;
      2:  v = 32'h09FB385B;
      3:  v = 32'h051111D4;
      4:  v = 32'h028B0D43;
      5:  v = 32'h0145D7E1;
      6:  v = 32'h00A2F61E;
      7:  v = 32'h00517C55;
      8:  v = 32'h0028BE53;
      9:  v = 32'h00145F2F;
      10: v = 32'h000A2F98;
      11: v = 32'h000517CC;
      12: v = 32'h00028BE6;
      13: v = 32'h000145F3;
      14: v = 32'h0000A2F9;
      15: v = 32'h0000517C;
      16: v = 32'h000028BE;
      17: v = 32'h0000145F;
      18: v = 32'h00000A2F;
      19: v = 32'h00000517;
      20: v = 32'h0000028B;
      21: v = 32'h00000145;
      22: v = 32'h000000A2;
      23: v = 32'h00000051;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

// File: design/aarm_fifo.sv
// Small register FIFO used as the front queue and the result queue.
module aarm_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wr_data,
  input  logic         pop,
  output logic [W-1:0] rd_data,
  output logic         full,
  output logic         empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [W-1:0] mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]   cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full    = (cnt_r == (AW+1)'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end
endmodule

// File: design/aarm_front.sv
// Front end: accepts items, folds the angle into the right half turn and queues them.
module aarm_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  logic [15:0]          in_angle,
  input  logic signed [15:0]   in_axis_x,
  input  logic signed [15:0]   in_axis_y,
  input  logic signed [15:0]   in_axis_z,
  input  logic                 q_pop,
  output aarm_pkg::front_item_t q_item,
  output logic                 q_empty
);
  aarm_pkg::front_item_t item;
  logic                  flip;

  // Second and third quarter turns get a half turn added, which toggles the top bit.
  assign flip      = in_angle[15] ^ in_angle[14];
  assign item.flip = flip;
  assign item.z    = signed'({in_angle[15] ^ flip, in_angle[14:0], 16'h0000});
  assign item.ax   = in_axis_x;
  assign item.ay   = in_axis_y;
  assign item.az   = in_axis_z;

  aarm_fifo #(
    .W     ($bits(aarm_pkg::front_item_t)),
    .DEPTH (aarm_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (in_push),
    .wr_data (item),
    .pop     (q_pop),
    .rd_data (q_item),
    .full    (in_full),
    .empty   (q_empty)
  );
endmodule

// File: design/aarm_cordic.sv
// Pipelined rotation-mode CORDIC, one stage per iteration.
module aarm_cordic #(
  parameter int NST = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  logic                           in_valid,
  input  aarm_pkg::front_item_t          in_item,
  output logic                           out_valid,
  output logic signed [aarm_pkg::XW-1:0] out_x,
  output logic signed [aarm_pkg::XW-1:0] out_y,
  output aarm_pkg::pass_t                out_pass,
  output logic                           busy
);
  localparam int XW = aarm_pkg::XW;

  logic signed [XW-1:0] x_r [NST];
  logic signed [XW-1:0] y_r [NST];
  logic signed [XW-1:0] z_r [NST];
  aarm_pkg::pass_t      pass_r [NST];
  logic [NST-1:0]       vld_r;

  for (genvar i = 0; i < NST; i++) begin : g_stage
    logic signed [XW-1:0] xi, yi, zi, dx, dy, at;
    aarm_pkg::pass_t      pi;
    logic                 vi;
    if (i == 0) begin : g_first
      assign xi      = aarm_pkg::GAIN_Q30;
      assign yi      = '0;
      assign zi      = XW'(in_item.z);
      assign pi.flip = in_item.flip;
      assign pi.ax   = in_item.ax;
      assign pi.ay   = in_item.ay;
      assign pi.az   = in_item.az;
      assign vi      = in_valid;
    end else begin : g_next
      assign xi = x_r[i-1];
      assign yi = y_r[i-1];
      assign zi = z_r[i-1];
      assign pi = pass_r[i-1];
      assign vi = vld_r[i-1];
    end
    assign dx = yi >>> i;
    assign dy = xi >>> i;
    assign at = signed'(XW'(aarm_pkg::atan_turn(i)));

    always_ff @(posedge clk) begin
      if (en) begin
        if (!zi[XW-1]) begin
          x_r[i] <= xi - dx;
          y_r[i] <= yi + dy;
          z_r[i] <= zi - at;
        end else begin
          x_r[i] <= xi + dx;
          y_r[i] <= yi - dy;
          z_r[i] <= zi + at;
        end
        pass_r[i] <= pi;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= vi;
      end
    end
  end

  assign out_valid = vld_r[NST-1];
  assign out_x     = x_r[NST-1];
  assign out_y     = y_r[NST-1];
  assign out_pass  = pass_r[NST-1];
  assign busy      = |vld_r;
endmodule

// File: design/aarm_back.sv
// Back end: CORDIC sine and cosine, then the Rodrigues products, sums and saturation.
module aarm_back #(
  parameter int CORDIC_STAGES = aarm_pkg::CORDIC_STAGES_DEF,
  parameter int FRAC_BITS     = aarm_pkg::FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  aarm_pkg::front_item_t q_item,
  input  logic                  q_empty,
  output logic                  q_pop,
  input  logic                  res_full,
  output logic                  res_push,
  output logic [9*16-1:0]       res_data,
  output aarm_pkg::back_st_t    st
);
  localparam int XW  = aarm_pkg::XW;
  localparam int NST = (CORDIC_STAGES < aarm_pkg::TABLE_LEN) ?
                       CORDIC_STAGES : aarm_pkg::TABLE_LEN;
  localparam int SH  = aarm_pkg::WORK_BITS - FRAC_BITS;
  localparam int CW  = FRAC_BITS + 3;
  localparam int KW  = CW + 1;
  localparam int PW  = 32;
  localparam int RW  = 16 + CW;
  localparam int OW  = PW + KW;
  localparam int SW  = OW + 1;
  localparam logic signed [OW-1:0] ORND = OW'(1) << (2*FRAC_BITS-1);
  localparam logic signed [RW-1:0] RRND = RW'(1) << (FRAC_BITS-1);
  localparam logic signed [KW-1:0] ONE  = KW'(1) << FRAC_BITS;

  logic                 en;
  logic                 cv_valid, cv_busy;
  logic signed [XW-1:0] cv_x, cv_y, xf, yf, xr, yr;
  aarm_pkg::pass_t      cv_pass;

  // Stage A: fold back and round.
  logic                 va_r;
  logic signed [CW-1:0] c_a_r, s_a_r;
  logic signed [KW-1:0] k_a_r;
  aarm_pkg::pass_t      p_a_r;
  // Stage B: axis products.
  logic                 vb_r;
  logic signed [PW-1:0] pq_b_r [6];
  logic signed [RW-1:0] cr_b_r [3];
  logic signed [CW-1:0] c_b_r;
  logic signed [KW-1:0] k_b_r;
  // Stage C: outer products with 1 - cos.
  logic                 vc_r;
  logic signed [OW-1:0] o_c_r [6];
  logic signed [RW-1:0] cr_c_r [3];
  logic signed [CW-1:0] c_c_r;

  logic signed [OW-1:0] orn [6];
  logic signed [RW-1:0] crn [3];
  logic signed [15:0]   ent [9];

  // The whole back end holds while the last stage waits on a full result queue.
  assign en       = !(vc_r && res_full);
  assign q_pop    = en && !q_empty;
  assign res_push = vc_r && !res_full;
  assign st.stall = !en;
  assign st.busy  = cv_busy || va_r || vb_r || vc_r;

  aarm_cordic #(.NST(NST)) u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (!q_empty),
    .in_item   (q_item),
    .out_valid (cv_valid),
    .out_x     (cv_x),
    .out_y     (cv_y),
    .out_pass  (cv_pass),
    .busy      (cv_busy)
  );

  assign xf = cv_pass.flip ? -cv_x : cv_x;
  assign yf = cv_pass.flip ? -cv_y : cv_y;

  if (SH > 0) begin : g_rnd
    localparam logic signed [XW-1:0] XRND = XW'(1) << (SH-1);
    assign xr = (xf + XRND) >>> SH;
    assign yr = (yf + XRND) >>> SH;
  end else begin : g_nornd
    assign xr = xf;
    assign yr = yf;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else if (en) begin
      va_r <= cv_valid;
      vb_r <= va_r;
      vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_a_r <= CW'(xr);
      s_a_r <= CW'(yr);
      k_a_r <= ONE - KW'(CW'(xr));
      p_a_r <= cv_pass;

      pq_b_r[0] <= p_a_r.ax * p_a_r.ax;
      pq_b_r[1] <= p_a_r.ay * p_a_r.ay;
      pq_b_r[2] <= p_a_r.az * p_a_r.az;
      pq_b_r[3] <= p_a_r.ax * p_a_r.ay;
      pq_b_r[4] <= p_a_r.ax * p_a_r.az;
      pq_b_r[5] <= p_a_r.ay * p_a_r.az;
      cr_b_r[0] <= RW'(p_a_r.ax) * RW'(s_a_r);
      cr_b_r[1] <= RW'(p_a_r.ay) * RW'(s_a_r);
      cr_b_r[2] <= RW'(p_a_r.az) * RW'(s_a_r);
      c_b_r     <= c_a_r;
      k_b_r     <= k_a_r;

      for (int j = 0; j < 6; j++) begin
        o_c_r[j] <= OW'(pq_b_r[j]) * OW'(k_b_r);
      end
      for (int j = 0; j < 3; j++) begin
        cr_c_r[j] <= cr_b_r[j];
      end
      c_c_r <= c_b_r;
    end
  end

  always_comb begin
    for (int j = 0; j < 6; j++) begin
      orn[j] = (o_c_r[j] + ORND) >>> (2*FRAC_BITS);
    end
    for (int j = 0; j < 3; j++) begin
      crn[j] = (cr_c_r[j] + RRND) >>> FRAC_BITS;
    end
  end

  function automatic logic signed [15:0] sat16(input logic signed [SW-1:0] v);
    logic signed [15:0] r;
    if (v > SW'(32767)) begin
      r = 16'sh7FFF;
    end else if (v < -SW'(32768)) begin
      r = -16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  // Index map: products xx yy zz xy xz yz, cross terms by x y z.
  assign ent[0] = sat16(SW'(orn[0]) + SW'(c_c_r));
  assign ent[1] = sat16(SW'(orn[3]) - SW'(crn[2]));
  assign ent[2] = sat16(SW'(orn[4]) + SW'(crn[1]));
  assign ent[3] = sat16(SW'(orn[3]) + SW'(crn[2]));
  assign ent[4] = sat16(SW'(orn[1]) + SW'(c_c_r));
  assign ent[5] = sat16(SW'(orn[5]) - SW'(crn[0]));
  assign ent[6] = sat16(SW'(orn[4]) - SW'(crn[1]));
  assign ent[7] = sat16(SW'(orn[5]) + SW'(crn[0]));
  assign ent[8] = sat16(SW'(orn[2]) + SW'(c_c_r));

  assign res_data = {ent[0], ent[1], ent[2], ent[3], ent[4],
                     ent[5], ent[6], ent[7], ent[8]};
endmodule

// File: design/axis_angle_rotation_matrix.sv
// Axis-angle rotation matrix: front queue, CORDIC, stages A, B and C, then the result queue.
// Throughput is one item per cycle while the back pipeline is not held by a full result queue.
// The whole back pipeline holds while its last stage waits on a full two-entry result queue.
// A four-entry front queue decouples input acceptance from the back pipeline.
// Synchronous active-low reset empties both queues and clears all pipeline valid bits.
`include "assert_macros.svh"
module axis_angle_rotation_matrix #(
  parameter int CORDIC_STAGES = aarm_pkg::CORDIC_STAGES_DEF,
  parameter int FRAC_BITS     = aarm_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic [15:0]        in_angle,
  input  logic signed [15:0] in_axis_x,
  input  logic signed [15:0] in_axis_y,
  input  logic signed [15:0] in_axis_z,
  output logic               out_empty,
  input  logic               out_pop,
  output logic signed [15:0] out_m_xx,
  output logic signed [15:0] out_m_xy,
  output logic signed [15:0] out_m_xz,
  output logic signed [15:0] out_m_yx,
  output logic signed [15:0] out_m_yy,
  output logic signed [15:0] out_m_yz,
  output logic signed [15:0] out_m_zx,
  output logic signed [15:0] out_m_zy,
  output logic signed [15:0] out_m_zz
);
  aarm_pkg::front_item_t q_item;
  aarm_pkg::back_st_t    back_st;
  logic                  q_pop, q_empty, res_full, res_push;
  logic [9*16-1:0]       res_data, out_data;

  aarm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_angle  (in_angle),
    .in_axis_x (in_axis_x),
    .in_axis_y (in_axis_y),
    .in_axis_z (in_axis_z),
    .q_pop     (q_pop),
    .q_item    (q_item),
    .q_empty   (q_empty)
  );

  aarm_back #(
    .CORDIC_STAGES (CORDIC_STAGES),
    .FRAC_BITS     (FRAC_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_item   (q_item),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .res_full (res_full),
    .res_push (res_push),
    .res_data (res_data),
    .st       (back_st)
  );

  aarm_fifo #(
    .W     (9*16),
    .DEPTH (aarm_pkg::OUT_DEPTH)
  ) u_out (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (res_push),
    .wr_data (res_data),
    .pop     (out_pop),
    .rd_data (out_data),
    .full    (res_full),
    .empty   (out_empty)
  );

  assign out_m_xx = out_data[8*16 +: 16];
  assign out_m_xy = out_data[7*16 +: 16];
  assign out_m_xz = out_data[6*16 +: 16];
  assign out_m_yx = out_data[5*16 +: 16];
  assign out_m_yy = out_data[4*16 +: 16];
  assign out_m_yz = out_data[3*16 +: 16];
  assign out_m_zx = out_data[2*16 +: 16];
  assign out_m_zy = out_data[1*16 +: 16];
  assign out_m_zz = out_data[0*16 +: 16];

  `ASSERT_NEXT(a_reset_clears, clk, !rst_n, out_empty && !in_full && !back_st.busy)
  `ASSERT_IMPLIES(a_stall_needs_result, clk, rst_n, back_st.stall, !out_empty && back_st.busy)
  `ASSERT_IMPLIES(a_idle_no_pop, clk, rst_n, !back_st.busy && q_empty, !res_push)
endmodule

// File: bench/tb.sv
// Self-checking testbench for the axis-angle rotation matrix block.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STAGES = aarm_pkg::CORDIC_STAGES_DEF;
  localparam int FRAC   = aarm_pkg::FRAC_BITS_DEF;
  localparam int LATENCY = STAGES + 5;

  typedef struct {
    logic signed [15:0] m [9];
  } matrix_t;

  // Predicts rotation matrices and checks them in arrival order.
  class rotation_scoreboard;
    matrix_t pending[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    static function longint floor_sh(longint v, int s);
      return v >>> s;
    endfunction

    static function longint round_sh(longint v, int s);
      if (s == 0) return v;
      return floor_sh(v + (longint'(1) << (s - 1)), s);
    endfunction

    static function logic signed [15:0] clamp16(longint v);
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[15:0];
    endfunction

    static function logic signed [15:0] matrix_entry(longint p, longint q, longint k,
                                                     longint diag, longint r, longint s,
                                                     bit plus);
      longint outer, cross_term;
      outer = round_sh(p * q * k, 2 * FRAC);
      cross_term = round_sh(r * s, FRAC);
      return clamp16(outer + diag + (plus ? cross_term : -cross_term));
    endfunction

    function void note_item(logic [15:0] ang, logic signed [15:0] ax,
                            logic signed [15:0] ay, logic signed [15:0] az);
      logic [31:0] phase;
      bit flip;
      longint x, y, z, dx, dy, c, s, k;
      int n;
      matrix_t m;
      phase = {ang, 16'h0};
      flip = (phase[31:30] == 2'd1) || (phase[31:30] == 2'd2);
      if (flip) phase = phase + 32'h80000000;
      z = longint'($signed(phase));
      x = 652032874;
      y = 0;
      n = STAGES < 24 ? STAGES : 24;
      for (int i = 0; i < n; i++) begin
        dx = floor_sh(y, i);
        dy = floor_sh(x, i);
        if (z >= 0) begin
          x -= dx; y += dy; z -= longint'(aarm_pkg::atan_turn(i));
        end else begin
          x += dx; y -= dy; z += longint'(aarm_pkg::atan_turn(i));
        end
      end
      if (flip) begin
        x = -x; y = -y;
      end
      c = round_sh(x, 30 - FRAC);
      s = round_sh(y, 30 - FRAC);
      k = (longint'(1) << FRAC) - c;
      m.m[0] = matrix_entry(ax, ax, k, c, 0, s, 1);
      m.m[1] = matrix_entry(ay, ax, k, 0, az, s, 0);
      m.m[2] = matrix_entry(az, ax, k, 0, ay, s, 1);
      m.m[3] = matrix_entry(ax, ay, k, 0, az, s, 1);
      m.m[4] = matrix_entry(ay, ay, k, c, 0, s, 1);
      m.m[5] = matrix_entry(az, ay, k, 0, ax, s, 0);
      m.m[6] = matrix_entry(ax, az, k, 0, ay, s, 0);
      m.m[7] = matrix_entry(ay, az, k, 0, ax, s, 1);
      m.m[8] = matrix_entry(az, az, k, c, 0, s, 1);
      pending.push_back(m);
    endfunction

    function void check_matrix(matrix_t got);
      string names [9] = '{"m_xx", "m_xy", "m_xz", "m_yx", "m_yy", "m_yz",
                           "m_zx", "m_zy", "m_zz"};
      matrix_t want;
      if (pending.size() == 0) begin
        $error("unexpected result item");
        errors++;
        return;
      end
      want = pending.pop_front();
      for (int i = 0; i < 9; i++)
        if (got.m[i] !== want.m[i]) begin
          $error("%s expected %0d actual %0d", names[i], want.m[i], got.m[i]);
          errors++;
        end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_push = 0;
  logic in_full;
  logic [15:0] in_angle = 0;
  logic signed [15:0] in_axis_x = 0, in_axis_y = 0, in_axis_z = 0;
  logic out_empty;
  logic out_pop = 0;
  logic signed [15:0] out_m_xx, out_m_xy, out_m_xz, out_m_yx, out_m_yy, out_m_yz;
  logic signed [15:0] out_m_zx, out_m_zy, out_m_zz;

  rotation_scoreboard board = new();
  bit calm = 0;
  bit sending_done = 0;

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  axis_angle_rotation_matrix uut (.*);

  // Note accepted items and check accepted results at each edge.
  always @(posedge clk) begin
    matrix_t got;
    if (rst_n) begin
      if (in_push && !in_full) board.note_item(in_angle, in_axis_x, in_axis_y, in_axis_z);
      if (out_pop && !out_empty) begin
        got.m = '{out_m_xx, out_m_xy, out_m_xz, out_m_yx, out_m_yy, out_m_yz,
                  out_m_zx, out_m_zy, out_m_zz};
        board.check_matrix(got);
      end
    end
  end

  // Result side: pop with random stall bursts, none near the end.
  initial begin
    int gap;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 16);
        out_pop <= 0;
        repeat (gap) @(posedge clk);
      end
      out_pop <= 1;
    end
  end

  task automatic send_item(logic [15:0] ang, logic [15:0] ax, logic [15:0] ay,
                           logic [15:0] az);
    in_push <= 1;
    in_angle <= ang;
    in_axis_x <= ax;
    in_axis_y <= ay;
    in_axis_z <= az;
    @(posedge clk);
    while (in_full) @(posedge clk);
  endtask

  task automatic idle_burst();
    in_push <= 0;
    repeat ($urandom_range(1, 16)) @(posedge clk);
  endtask

  function automatic logic [15:0] random_component();
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(0, 32768)) - 16384);
      2: return $urandom_range(0, 1) ? 16'h4000 : 16'hC000;
      default: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
    endcase
  endfunction

  initial begin
    logic [15:0] ax, ay, az;
    int rnd_x, rnd_y;
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // Directed: quarter turns, axis extremes and non-unit axes that saturate.
    send_item(16'h0000, 16'h4000, 16'h0000, 16'h0000);
    send_item(16'h4000, 16'h0000, 16'h4000, 16'h0000);
    send_item(16'h8000, 16'h0000, 16'h0000, 16'h4000);
    send_item(16'hC000, 16'h4000, 16'h0000, 16'h0000);
    send_item(16'hFFFF, 16'h2D41, 16'h2D41, 16'h0000);
    send_item(16'h3FFF, 16'h24F3, 16'h24F3, 16'h24F3);
    send_item(16'h4001, 16'hDB0D, 16'h24F3, 16'hDB0D);
    send_item(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_item(16'h8001, 16'h8000, 16'h8000, 16'h8000);
    send_item(16'hBFFF, 16'h7FFF, 16'h8000, 16'h0000);
    send_item(16'h2000, 16'h0000, 16'h0000, 16'h0000);
    send_item(16'h6000, 16'hFFFF, 16'h0001, 16'h8000);
    send_item(16'hA000, 16'h5555, 16'hAAAA, 16'h7FFF);
    send_item(16'hE000, 16'hC000, 16'hC000, 16'hC000);
    in_push <= 0;
    // The sender holds off until every expected result has come.
    while (board.pending.size() != 0) @(posedge clk);
    for (int n = 0; n < 1200; n++) begin
      if (n == 1000) calm = 1;
      if (!calm && $urandom_range(0, 7) == 0) idle_burst();
      if ($urandom_range(0, 1)) begin
        // Near-unit axis from a random pair plus derived third component.
        rnd_x = $urandom_range(0, 23170) - 11585;
        rnd_y = $urandom_range(0, 23170) - 11585;
        ax = 16'(rnd_x);
        ay = 16'(rnd_y);
        az = 16'($rtoi($sqrt(268435456.0 - rnd_x * rnd_x - rnd_y * rnd_y)));
        if ($urandom_range(0, 1)) az = -az;
      end else begin
        ax = random_component();
        ay = random_component();
        az = random_component();
      end
      send_item(16'($urandom), ax, ay, az);
    end
    in_push <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (board.errors == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  initial begin
    #2ms;
    $display("Mismatches found");
    $finish;
  end
endmodule
